### rtl/array_min_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Array min priority queue assertion macros
// Shorthand for the clocked, reset-gated checks of the queue.
// ----------------------------------------------------------------------------
`ifndef ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH

// A condition that holds at every edge outside reset.
`define AMPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define AMPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define AMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ampq_pkg.sv
// ----------------------------------------------------------------------------
// Array min priority queue package
// Default sizes, request and status codes, and the compare result type.
// ----------------------------------------------------------------------------
package ampq_pkg;

  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned ID_BITS_DEF   = 10;
  localparam int unsigned DIST_BITS_DEF = 32;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_SET     = 2'd2,
    REQ_PEEK    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic dist_lt;
    logic id_eq;
  } cmp_res_t;

endpackage

### rtl/ampq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ampq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/ampq_cmp.sv
// ----------------------------------------------------------------------------
// Array min priority queue compare unit
// Compares one stored entry with the running minimum and the request key.
// ----------------------------------------------------------------------------
module ampq_cmp
  import ampq_pkg::*;
#(
  parameter int unsigned ID_BITS   = ID_BITS_DEF,
  parameter int unsigned DIST_BITS = DIST_BITS_DEF
) (
  input  logic [ID_BITS-1:0]   entry_id_i,
  input  logic [DIST_BITS-1:0] entry_dist_i,
  input  logic [DIST_BITS-1:0] best_dist_i,
  input  logic [ID_BITS-1:0]   key_id_i,
  output cmp_res_t             res_o
);

  assign res_o.dist_lt = entry_dist_i < best_dist_i;
  assign res_o.id_eq   = entry_id_i == key_id_i;

endmodule

### rtl/array_min_priority_queue.sv
// ----------------------------------------------------------------------------
// Array min priority queue
// Unsorted store of node ids and distances with insert, extract-min,
// set-key and peek requests, served one entry per cycle from a RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         node_id, distance                           req_type
// m_axis    out        out_node, out_distance, now_empty, count    status
//
// Insert answers straight from idle; peek and set-key scan the held entries,
// and extract scans them and then moves the entries above the minimum down a
// place; the scan and the shift both go through the single RAM read port one
// entry a cycle. No new request is taken until the result has been taken.
// Reset clears the count and the sequencer; the RAM is not cleared.
// ----------------------------------------------------------------------------
`include "array_min_priority_queue_macros.svh"

module array_min_priority_queue
  import ampq_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF,
  parameter int unsigned DIST_BITS = DIST_BITS_DEF,
  localparam int unsigned AW       = $clog2(DEPTH),
  localparam int unsigned CW       = $clog2(DEPTH + 1),
  localparam int unsigned EW       = ID_BITS + DIST_BITS,
  localparam int unsigned SDW      = ((EW + 7) / 8) * 8,
  localparam int unsigned MOW      = EW + 1 + CW,
  localparam int unsigned MDW      = ((MOW + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [SDW-1:0] s_axis_tdata_i,  // node_id, distance
  input  logic [1:0]     s_axis_tuser_i,  // req_type
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [MDW-1:0] m_axis_tdata_o,  // out_node, out_distance, now_empty, entry_count
  output logic [1:0]     m_axis_tuser_o   // status
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic [AW-1:0]        cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;
  logic                 wv_q, wv_d;
  req_e                 req_q, req_d;
  logic [ID_BITS-1:0]   key_id_q, key_id_d;
  logic [DIST_BITS-1:0] key_dist_q, key_dist_d;
  logic [ID_BITS-1:0]   best_id_q, best_id_d;
  logic [DIST_BITS-1:0] best_dist_q, best_dist_d;
  logic [AW-1:0]        best_pos_q, best_pos_d;
  logic [ID_BITS-1:0]   res_node_q, res_node_d;
  logic [DIST_BITS-1:0] res_dist_q, res_dist_d;
  status_e              res_status_q, res_status_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic [DIST_BITS-1:0] rd_dist;
  cmp_res_t             cmp;

  logic                 s_accept;
  req_e                 s_req;
  logic [ID_BITS-1:0]   s_id;
  logic [DIST_BITS-1:0] s_dist;
  logic                 take;
  logic                 last;
  logic [MOW-1:0]       m_payload;

  assign s_req   = req_e'(s_axis_tuser_i);
  assign s_id    = s_axis_tdata_i[ID_BITS-1:0];
  assign s_dist  = s_axis_tdata_i[EW-1:ID_BITS];
  assign rd_id   = ram_rdata[ID_BITS-1:0];
  assign rd_dist = ram_rdata[EW-1:ID_BITS];

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = state_q == ST_RESP;
  assign m_payload       = {count_q, count_q == '0, res_dist_q, res_node_q};
  assign m_axis_tdata_o  = MDW'(m_payload);
  assign m_axis_tuser_o  = res_status_q;

  ampq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ampq_cmp #(
    .ID_BITS  (ID_BITS),
    .DIST_BITS(DIST_BITS)
  ) u_cmp (
    .entry_id_i  (rd_id),
    .entry_dist_i(rd_dist),
    .best_dist_i (best_dist_q),
    .key_id_i    (key_id_q),
    .res_o       (cmp)
  );

  // The first entry of a scan always becomes the running minimum.
  assign take = (cmp_idx_q == '0) || cmp.dist_lt;
  assign last = CW'(cmp_idx_q) == (count_q - CW'(1));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    cmp_idx_d    = cmp_idx_q;
    wr_addr_d    = wr_addr_q;
    wv_d         = wv_q;
    req_d        = req_q;
    key_id_d     = key_id_q;
    key_dist_d   = key_dist_q;
    best_id_d    = best_id_q;
    best_dist_d  = best_dist_q;
    best_pos_d   = best_pos_q;
    res_node_d   = res_node_q;
    res_dist_d   = res_dist_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = {s_dist, s_id};
    ram_raddr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          req_d        = s_req;
          key_id_d     = s_id;
          key_dist_d   = s_dist;
          res_node_d   = '0;
          res_dist_d   = '0;
          res_status_d = STATUS_OK;
          rd_idx_d     = CW'(1);
          cmp_idx_d    = '0;
          unique case (s_req) inside
            REQ_INSERT: begin
              state_d = ST_RESP;
              if (count_q == CW'(DEPTH)) begin
                res_status_d = STATUS_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            REQ_SET: begin
              if (count_q == '0) begin
                res_status_d = STATUS_NOT_FOUND;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            REQ_EXTRACT, REQ_PEEK: begin
              if (count_q == '0) begin
                res_status_d = STATUS_EMPTY;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_raddr = rd_idx_q[AW-1:0];
        cmp_idx_d = cmp_idx_q + AW'(1);
        if (rd_idx_q < count_q) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (req_q == REQ_SET) begin
          if (cmp.id_eq) begin
            ram_we    = 1'b1;
            ram_waddr = cmp_idx_q;
            ram_wdata = {key_dist_q, rd_id};
            state_d   = ST_RESP;
          end else if (last) begin
            res_status_d = STATUS_NOT_FOUND;
            state_d      = ST_RESP;
          end
        end else begin
          if (take) begin
            best_id_d   = rd_id;
            best_dist_d = rd_dist;
            best_pos_d  = cmp_idx_q;
          end
          if (last) begin
            res_node_d = best_id_d;
            res_dist_d = best_dist_d;
            if (req_q == REQ_EXTRACT) begin
              rd_idx_d = CW'(best_pos_d) + CW'(1);
              wv_d     = 1'b0;
              state_d  = ST_SHIFT;
            end else begin
              state_d = ST_RESP;
            end
          end
        end
      end
      ST_SHIFT: begin
        // Entry read last cycle moves down one place while the next is read.
        ram_raddr = rd_idx_q[AW-1:0];
        if (wv_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
        if (rd_idx_q < count_q) begin
          wr_addr_d = AW'(rd_idx_q - CW'(1));
          wv_d      = 1'b1;
          rd_idx_d  = rd_idx_q + CW'(1);
        end else begin
          wv_d    = 1'b0;
          count_d = count_q - CW'(1);
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      wv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      cmp_idx_q <= cmp_idx_d;
      wv_q      <= wv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q    <= wr_addr_d;
    req_q        <= req_d;
    key_id_q     <= key_id_d;
    key_dist_q   <= key_dist_d;
    best_id_q    <= best_id_d;
    best_dist_q  <= best_dist_d;
    best_pos_q   <= best_pos_d;
    res_node_q   <= res_node_d;
    res_dist_q   <= res_dist_d;
    res_status_q <= res_status_d;
  end

  `AMPQ_ASSERT(a_count_range, count_q <= CW'(DEPTH), "Entry count exceeds the depth.")
  `AMPQ_ASSERT(a_hs_excl, !(s_axis_tready_o && m_axis_tvalid_o), "Ready while a result waits.")
  `AMPQ_ASSERT_NEXT(a_insert_grows, s_accept && (s_req == REQ_INSERT) && (count_q != CW'(DEPTH)), count_q == $past(count_q) + CW'(1), "Accepted insert did not add an entry.")
  `AMPQ_ASSERT_IMPL(a_empty_status, m_axis_tvalid_o && (res_status_q == STATUS_EMPTY), count_q == '0, "Empty status with entries held.")

endmodule

### tb/sv/array_min_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array min priority queue testbench
// Drives insert, extract-min, set-key and peek requests into the queue over
// its request stream and checks every result against a predictor or a typed
// table row. The predictor keeps its own copy of the stored entries. The
// directed table covers the empty and full store, ties, absent and repeated
// ids and the extremes of the fields. Random requests then fill and drain
// the store in phases. Both stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
module array_min_priority_queue_test;
  import ampq_pkg::*;

  localparam int unsigned DEPTH     = DEPTH_DEF;
  localparam int unsigned ID_BITS   = ID_BITS_DEF;
  localparam int unsigned DIST_BITS = DIST_BITS_DEF;
  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int unsigned EW        = ID_BITS + DIST_BITS;
  localparam int unsigned SDW       = ((EW + 7) / 8) * 8;
  localparam int unsigned MDW       = ((EW + 1 + CW + 7) / 8) * 8;
  localparam int unsigned RANDOM_REQUESTS = 1060;
  localparam int unsigned SEGMENT   = 40;

  typedef logic [ID_BITS-1:0]   node_t;
  typedef logic [DIST_BITS-1:0] dist_t;

  typedef struct packed {
    node_t         node;
    dist_t         distance;
    status_e       status;
    logic          empty;
    logic [CW-1:0] count;
  } result_t;

  typedef struct packed {
    req_e          req;
    node_t         node;
    dist_t         distance;
    logic [7:0]    reps;
    logic          typed;
    node_t         x_node;
    dist_t         x_dist;
    status_e       x_status;
    logic [CW-1:0] x_count;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 22;

  // Rows with typed set hold their own expected result; the others use the predictor.
  // Repeated inserts step the id up and the distance down on each repeat.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{REQ_PEEK,    10'd0,    32'd0,          8'd1,  1'b1, 10'd0,    32'd0,          STATUS_EMPTY,     7'd0},
    '{REQ_EXTRACT, 10'd1023, 32'hFFFF_FFFF,  8'd1,  1'b1, 10'd0,    32'd0,          STATUS_EMPTY,     7'd0},
    '{REQ_SET,     10'd1023, 32'hFFFF_FFFF,  8'd1,  1'b1, 10'd0,    32'd0,          STATUS_NOT_FOUND, 7'd0},
    '{REQ_INSERT,  10'd1023, 32'hFFFF_FFFF,  8'd1,  1'b1, 10'd0,    32'd0,          STATUS_OK,        7'd1},
    '{REQ_PEEK,    10'd0,    32'd0,          8'd1,  1'b1, 10'd1023, 32'hFFFF_FFFF,  STATUS_OK,        7'd1},
    '{REQ_INSERT,  10'd0,    32'd0,          8'd1,  1'b1, 10'd0,    32'd0,          STATUS_OK,        7'd2},
    '{REQ_PEEK,    10'd1023, 32'hFFFF_FFFF,  8'd1,  1'b1, 10'd0,    32'd0,          STATUS_OK,        7'd2},
    '{REQ_SET,     10'd1023, 32'd0,          8'd1,  1'b1, 10'd0,    32'd0,          STATUS_OK,        7'd2},
    '{REQ_PEEK,    10'd0,    32'd0,          8'd1,  1'b1, 10'd1023, 32'd0,          STATUS_OK,        7'd2},
    '{REQ_SET,     10'd512,  32'd7,          8'd1,  1'b1, 10'd0,    32'd0,          STATUS_NOT_FOUND, 7'd2},
    '{REQ_INSERT,  10'd5,    32'd100,        8'd1,  1'b1, 10'd0,    32'd0,          STATUS_OK,        7'd3},
    '{REQ_INSERT,  10'd5,    32'd200,        8'd1,  1'b1, 10'd0,    32'd0,          STATUS_OK,        7'd4},
    '{REQ_SET,     10'd5,    32'd1,          8'd1,  1'b1, 10'd0,    32'd0,          STATUS_OK,        7'd4},
    '{REQ_EXTRACT, 10'd0,    32'd0,          8'd1,  1'b1, 10'd1023, 32'd0,          STATUS_OK,        7'd3},
    '{REQ_EXTRACT, 10'd0,    32'd0,          8'd1,  1'b1, 10'd0,    32'd0,          STATUS_OK,        7'd2},
    '{REQ_EXTRACT, 10'd0,    32'd0,          8'd1,  1'b1, 10'd5,    32'd1,          STATUS_OK,        7'd1},
    '{REQ_PEEK,    10'd0,    32'd0,          8'd1,  1'b1, 10'd5,    32'd200,        STATUS_OK,        7'd1},
    '{REQ_INSERT,  10'h155,  32'hAAAA_5555,  8'd63, 1'b0, 10'd0,    32'd0,          STATUS_OK,        7'd0},
    '{REQ_INSERT,  10'h2AA,  32'h5555_AAAA,  8'd1,  1'b1, 10'd0,    32'd0,          STATUS_FULL,      7'd64},
    '{REQ_SET,     10'h155,  32'd0,          8'd1,  1'b0, 10'd0,    32'd0,          STATUS_OK,        7'd0},
    '{REQ_PEEK,    10'd0,    32'd0,          8'd1,  1'b0, 10'd0,    32'd0,          STATUS_OK,        7'd0},
    '{REQ_EXTRACT, 10'd0,    32'd0,          8'd4,  1'b0, 10'd0,    32'd0,          STATUS_OK,        7'd0}
  };

  logic           clk_i           = 1'b0;
  logic           rst_ni          = 1'b0;
  logic           s_axis_tvalid_i = 1'b0;
  logic           s_axis_tready_o;
  logic [SDW-1:0] s_axis_tdata_i  = '0;  // node_id, distance
  logic [1:0]     s_axis_tuser_i  = REQ_INSERT;  // req_type
  logic           m_axis_tvalid_o;
  logic           m_axis_tready_i = 1'b0;
  logic [MDW-1:0] m_axis_tdata_o;  // out_node, out_distance, now_empty, entry_count
  logic [1:0]     m_axis_tuser_o;  // status

  node_t       held_ids [DEPTH];
  dist_t       held_dists [DEPTH];
  int unsigned held_total = 0;

  result_t     awaited_results [$];
  int unsigned mismatches = 0;
  int unsigned src_gap_max = 4;
  int unsigned sink_gap_max = 4;

  array_min_priority_queue DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Applies one request to the predicted store and returns the result it gives.
  function automatic result_t serve_request(input req_e req, input node_t node,
                                            input dist_t distance);
    result_t r;
    int      best;
    int      slot;
    r        = '0;
    r.status = STATUS_OK;
    case (req)
      REQ_INSERT: begin
        if (held_total >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          held_ids[held_total]   = node;
          held_dists[held_total] = distance;
          held_total++;
        end
      end
      REQ_EXTRACT, REQ_PEEK: begin
        if (held_total == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < held_total; i++) begin
            if (held_dists[i] < held_dists[best]) best = i;
          end
          r.node     = held_ids[best];
          r.distance = held_dists[best];
          if (req == REQ_EXTRACT) begin
            for (int i = best + 1; i < held_total; i++) begin
              held_ids[i-1]   = held_ids[i];
              held_dists[i-1] = held_dists[i];
            end
            held_total--;
          end
        end
      end
      default: begin
        slot = -1;
        for (int i = 0; i < held_total; i++) begin
          if (slot < 0 && held_ids[i] == node) slot = i;
        end
        if (slot < 0) r.status = STATUS_NOT_FOUND;
        else held_dists[slot] = distance;
      end
    endcase
    r.empty = (held_total == 0);
    r.count = CW'(held_total);
    return r;
  endfunction

  // Presents one request, waits for it to be taken and files its expected result.
  task automatic send_request(input req_e req, input node_t node, input dist_t distance,
                              input logic typed, input result_t typed_result);
    int unsigned gap;
    result_t     predicted;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= SDW'({distance, node});
    s_axis_tuser_i  <= req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = serve_request(req, node, distance);
    awaited_results.push_back(typed ? typed_result : predicted);
  endtask

  function automatic dist_t pick_distance();
    case ($urandom_range(0, 5))
      0:       return dist_t'($urandom_range(0, 1));
      1:       return {DIST_BITS{1'b1}} - dist_t'($urandom_range(0, 1));
      2, 3:    return dist_t'($urandom_range(0, 15));
      default: return dist_t'($urandom());
    endcase
  endfunction

  function automatic node_t pick_node();
    if ($urandom_range(0, 1) == 0) return node_t'($urandom_range(0, 15));
    return node_t'($urandom());
  endfunction

  initial begin
    result_t     typed_result;
    int unsigned fill_pct;
    int unsigned pick;
    req_e        req;
    node_t       node;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[r]) begin
      typed_result = '{PLAN[r].x_node, PLAN[r].x_dist, PLAN[r].x_status,
                       PLAN[r].x_count == 0, PLAN[r].x_count};
      for (int k = 0; k < PLAN[r].reps; k++) begin
        send_request(PLAN[r].req, PLAN[r].node + node_t'(k * 37),
                     PLAN[r].distance - dist_t'(k * 32'h0101_0101), PLAN[r].typed,
                     typed_result);
      end
    end

    fill_pct = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % SEGMENT == 0) begin
        case ($urandom_range(0, 2))
          0:       fill_pct = 85;
          1:       fill_pct = 50;
          default: fill_pct = 15;
        endcase
        src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 4;
        sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      end
      pick = $urandom_range(0, 99);
      if (pick < fill_pct) begin
        req = REQ_INSERT;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: req = REQ_EXTRACT;
          5, 6, 7:       req = REQ_SET;
          default:       req = REQ_PEEK;
        endcase
      end
      node = pick_node();
      if (req == REQ_SET && held_total != 0 && $urandom_range(0, 3) != 0) begin
        node = held_ids[$urandom_range(0, held_total - 1)];
      end
      send_request(req, node, pick_distance(), 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("array_min_priority_queue_test: PASS");
    end else begin
      $display("array_min_priority_queue_test: FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    while (!rst_ni) @(posedge clk_i);
    m_axis_tready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
      gap = $urandom_range(0, sink_gap_max);
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.node     = m_axis_tdata_o[ID_BITS-1:0];
      got.distance = m_axis_tdata_o[ID_BITS +: DIST_BITS];
      got.empty    = m_axis_tdata_o[EW];
      got.count    = m_axis_tdata_o[EW + 1 +: CW];
      got.status   = status_e'(m_axis_tuser_o);
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (got.node !== want.node)
          report_mismatch($sformatf("out_node %0d, expected %0d", got.node, want.node));
        if (got.distance !== want.distance)
          report_mismatch($sformatf("out_distance %0d, expected %0d", got.distance,
                                    want.distance));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser_o, want.status));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("now_empty %0d, expected %0d", got.empty, want.empty));
        if (got.count !== want.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", got.count, want.count));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("array_min_priority_queue_test: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ampq_pkg.sv
rtl/ampq_ram.sv
rtl/ampq_cmp.sv
rtl/array_min_priority_queue.sv
tb/sv/array_min_priority_queue_test.sv
